FILE: hw/rtl/dccm_pkg.sv
// Shared constants and types for the disc coverage counter map.
// Holds register indexes, reset values, default sizes and the sequencer codes.
// No dependencies.
`timescale 1ns / 1ps

package dccm_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned DCCM_MAX_FIELD   = 256;
  localparam int unsigned DCCM_MAX_RADIUS  = 15;
  localparam int unsigned DCCM_COUNT_WIDTH = 8;

  // port widths fixed by the word layout
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_W       = 17;
  localparam int unsigned OUT_TDATA_W = 24;

  // largest covered count that the result word can show
  localparam logic [OUT_W-1:0] OUT_MAX = 17'h1FFFF;

  // register reset values
  localparam logic [8:0] FIELD_LENGTH_RST = 9'd256;
  localparam logic [3:0] SENSE_RADIUS_RST = 4'd4;
  localparam logic [7:0] SINK_X_RST       = 8'd0;
  localparam logic [7:0] SINK_Y_RST       = 8'd0;

  // operation carried in tuser
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // register map, one register per 32-bit word
  typedef enum logic [1:0] {
    REG_FIELD_LENGTH = 2'd0,
    REG_SENSE_RADIUS = 2'd1,
    REG_SINK_X       = 2'd2,
    REG_SINK_Y       = 2'd3
  } reg_idx_t;

  // sequencer states
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_WRITE = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_OUT   = 6'b100000
  } st_t;

  // which part of the disc is being stamped
  typedef enum logic [3:0] {
    PH_CENTRE = 4'b0001,
    PH_ROW    = 4'b0010,
    PH_COL    = 4'b0100,
    PH_QUAD   = 4'b1000
  } ph_t;

endpackage

FILE: hw/rtl/disc_coverage_counter_map.sv
// Disc coverage counter map: grid of saturating cover counters in one memory,
// stamped cell by cell by a small sequencer around a shared read-modify-write path.
// Depends on dccm_pkg.
//
//   channel | ports                      | word
//   --------+----------------------------+------------------------------------------
//   input   | in_tvalid/in_tready        | tdata: sensor_x, sensor_y; tuser: op
//   result  | out_tvalid/out_tready      | tdata: covered_cells (zero padded)
//   config  | cfg_psel .. cfg_pready     | field_length, sense_radius, sink_x, sink_y
//
// Each stamped cell is read from the counter memory and then written back, each
// quadrant row/column pair is first put through a radius check, and each quadrant
// row ends with one failing check. After reset a clearing pass writes zero to all
// 2^(2*clog2(MAX_FIELD)) counters before the first word is taken. The input is held
// off while an item runs; a finished result waits in the output register and the
// next item is accepted once it is loaded there.
`timescale 1ns / 1ps

module disc_coverage_counter_map #(
  parameter int unsigned MAX_FIELD   = dccm_pkg::DCCM_MAX_FIELD,
  parameter int unsigned MAX_RADIUS  = dccm_pkg::DCCM_MAX_RADIUS,
  parameter int unsigned COUNT_WIDTH = dccm_pkg::DCCM_COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dccm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] sensor_x, [15:8] sensor_y
  input  logic                             in_tuser,   // [0] op
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dccm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [16:0] covered_cells
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [dccm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [dccm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [dccm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  import dccm_pkg::*;

  // derived sizes
  localparam int unsigned AW     = (MAX_FIELD > 1) ? $clog2(MAX_FIELD) : 1;
  localparam int unsigned MAW    = 2 * AW;
  localparam int unsigned DEPTH  = 1 << MAW;
  localparam int unsigned RW     = (MAX_RADIUS > 1) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int unsigned RXW    = (RW > 4) ? RW : 4;
  localparam int unsigned SQW    = 2 * RW;
  localparam int unsigned FLW    = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int unsigned CW     = FLW + 1;
  localparam int unsigned TOT_W  = MAW + 1;
  localparam int unsigned SAT_W  = (TOT_W > OUT_W) ? TOT_W : OUT_W;

  // configuration registers
  logic [8:0] field_length_r;
  logic [3:0] sense_radius_r;
  logic [7:0] sink_x_r;
  logic [7:0] sink_y_r;

  // sequencer and datapath registers
  st_t                    state_r, state_nxt;
  ph_t                    phase_r, phase_nxt;
  logic [RW-1:0]          i_r, i_nxt;
  logic [RW-1:0]          j_r, j_nxt;
  logic [1:0]             k_r, k_nxt;
  logic [SQW-1:0]         ii_r, ii_nxt;
  logic [SQW-1:0]         jj_r, jj_nxt;
  logic [SQW-1:0]         rr_r, rr_nxt;
  logic [RW-1:0]          r_r, r_nxt;
  logic [COORD_W-1:0]     sx_r, sx_nxt;
  logic [COORD_W-1:0]     sy_r, sy_nxt;
  logic                   op_r, op_nxt;
  logic [MAW-1:0]         addr_r, addr_nxt;
  logic [MAW-1:0]         clr_r, clr_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic [COUNT_WIDTH-1:0] rd_r;

  // counter memory
  logic [COUNT_WIDTH-1:0] cnt_mem [DEPTH];
  logic                   mem_we;
  logic [MAW-1:0]         mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;

  // combinational helpers
  logic [FLW-1:0]         fl_ext;
  logic [FLW-1:0]         side;
  logic [RXW-1:0]         rad_ext;
  logic [RW-1:0]          r_eff;
  logic [RW-1:0]          ax, ay;
  logic                   neg_x, neg_y;
  logic [CW-1:0]          cx_s, cy_s;
  logic [AW-1:0]          col, row;
  logic [MAW-1:0]         touch_addr;
  logic [COUNT_WIDTH-1:0] wr_val;
  logic                   cnt_up, cnt_down;
  logic [SQW:0]           sq_sum;
  logic [SAT_W-1:0]       tot_ext;
  logic [OUT_W-1:0]       tot_sat;
  logic                   reg_we;

  // off-grid coordinates go to the sink, and a sink beyond the store saturates
  function automatic logic [AW-1:0] map_coord(input logic [CW-1:0] c,
                                              input logic [FLW-1:0] sd,
                                              input logic [7:0] sink);
    logic [AW-1:0] v;
    if (c[CW-1] || (c[CW-2:0] >= sd)) begin
      if (FLW'(sink) >= FLW'(MAX_FIELD)) begin
        v = AW'(MAX_FIELD - 1);
      end else begin
        v = AW'(sink);
      end
    end else begin
      v = AW'(c);
    end
    return v;
  endfunction

  // effective side and radius
  assign fl_ext  = FLW'(field_length_r);
  assign side    = (fl_ext < FLW'(MAX_FIELD)) ? fl_ext : FLW'(MAX_FIELD);
  assign rad_ext = RXW'(sense_radius_r);
  assign r_eff   = (rad_ext < RXW'(MAX_RADIUS)) ? RW'(rad_ext) : RW'(MAX_RADIUS);

  // offsets of the current stamp
  always_comb begin
    ax    = '0;
    ay    = '0;
    neg_x = 1'b0;
    neg_y = 1'b0;
    case (phase_r)
      PH_CENTRE: begin
        ax = '0;
        ay = '0;
      end
      PH_ROW: begin
        ax    = j_r;
        neg_x = ~k_r[0];
      end
      PH_COL: begin
        ay    = i_r;
        neg_y = ~k_r[0];
      end
      PH_QUAD: begin
        ax    = j_r;
        ay    = i_r;
        neg_x = ~k_r[0];
        neg_y = (k_r == 2'd0) || (k_r == 2'd3);
      end
      default: begin
        ax = '0;
        ay = '0;
      end
    endcase
  end

  // cell address of the current stamp
  assign cx_s       = neg_x ? (CW'(sx_r) - CW'(ax)) : (CW'(sx_r) + CW'(ax));
  assign cy_s       = neg_y ? (CW'(sy_r) - CW'(ay)) : (CW'(sy_r) + CW'(ay));
  assign col        = map_coord(cx_s, side, sink_x_r);
  assign row        = map_coord(cy_s, side, sink_y_r);
  assign touch_addr = {row, col};

  // counter update: saturate on add, floor at zero on remove
  always_comb begin
    wr_val   = rd_r;
    cnt_up   = 1'b0;
    cnt_down = 1'b0;
    if (op_r == OP_ADD) begin
      if (rd_r != {COUNT_WIDTH{1'b1}}) begin
        wr_val = rd_r + COUNT_WIDTH'(1);
        cnt_up = (rd_r == '0);
      end
    end else begin
      if (rd_r != '0) begin
        wr_val   = rd_r - COUNT_WIDTH'(1);
        cnt_down = (rd_r == COUNT_WIDTH'(1));
      end
    end
  end

  // quadrant radius check
  assign sq_sum = (SQW + 1)'(ii_r) + (SQW + 1)'(jj_r);

  // result saturation
  assign tot_ext = SAT_W'(total_r);
  assign tot_sat = (tot_ext > SAT_W'(OUT_MAX)) ? OUT_MAX : OUT_W'(tot_ext);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    ii_nxt        = ii_r;
    jj_nxt        = jj_r;
    rr_nxt        = rr_r;
    r_nxt         = r_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    clr_nxt       = clr_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = wr_val;

    // result word taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + MAW'(1);
        if (clr_r == {MAW{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          sx_nxt    = in_tdata[COORD_W-1:0];
          sy_nxt    = in_tdata[2*COORD_W-1:COORD_W];
          r_nxt     = r_eff;
          rr_nxt    = SQW'(r_eff) * SQW'(r_eff);
          phase_nxt = PH_CENTRE;
          k_nxt     = 2'd0;
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        addr_nxt  = touch_addr;
        state_nxt = ST_WRITE;
      end

      ST_WRITE: begin
        mem_we = 1'b1;
        if (cnt_up) begin
          total_nxt = total_r + TOT_W'(1);
        end else if (cnt_down) begin
          total_nxt = total_r - TOT_W'(1);
        end
        state_nxt = ST_READ;
        case (phase_r)
          PH_CENTRE: begin
            if (r_r == '0) begin
              state_nxt = ST_OUT;
            end else begin
              phase_nxt = PH_ROW;
              j_nxt     = RW'(1);
              k_nxt     = 2'd0;
            end
          end
          PH_ROW: begin
            if (!k_r[0]) begin
              k_nxt = 2'd1;
            end else if (j_r == r_r) begin
              phase_nxt = PH_COL;
              i_nxt     = RW'(1);
              k_nxt     = 2'd0;
            end else begin
              j_nxt = j_r + RW'(1);
              k_nxt = 2'd0;
            end
          end
          PH_COL: begin
            if (!k_r[0]) begin
              k_nxt = 2'd1;
            end else if (i_r == r_r) begin
              phase_nxt = PH_QUAD;
              i_nxt     = RW'(1);
              j_nxt     = RW'(1);
              ii_nxt    = SQW'(1);
              jj_nxt    = SQW'(1);
              k_nxt     = 2'd0;
              state_nxt = ST_CHECK;
            end else begin
              i_nxt = i_r + RW'(1);
              k_nxt = 2'd0;
            end
          end
          PH_QUAD: begin
            if (k_r != 2'd3) begin
              k_nxt = k_r + 2'd1;
            end else begin
              k_nxt = 2'd0;
              if (j_r == r_r) begin
                if (i_r == r_r) begin
                  state_nxt = ST_OUT;
                end else begin
                  i_nxt     = i_r + RW'(1);
                  ii_nxt    = ii_r + SQW'({i_r, 1'b1});
                  j_nxt     = RW'(1);
                  jj_nxt    = SQW'(1);
                  state_nxt = ST_CHECK;
                end
              end else begin
                j_nxt     = j_r + RW'(1);
                jj_nxt    = jj_r + SQW'({j_r, 1'b1});
                state_nxt = ST_CHECK;
              end
            end
          end
          default: begin
            state_nxt = ST_OUT;
          end
        endcase
      end

      ST_CHECK: begin
        if (sq_sum <= (SQW + 1)'(rr_r)) begin
          state_nxt = ST_READ;
        end else if ((j_r == RW'(1)) || (i_r == r_r)) begin
          // no later row of the quadrant can lie inside the disc
          state_nxt = ST_OUT;
        end else begin
          i_nxt     = i_r + RW'(1);
          ii_nxt    = ii_r + SQW'({i_r, 1'b1});
          j_nxt     = RW'(1);
          jj_nxt    = SQW'(1);
          state_nxt = ST_CHECK;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = tot_sat;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= PH_CENTRE;
      clr_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item and loop payload
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    ii_r       <= ii_nxt;
    jj_r       <= jj_nxt;
    rr_r       <= rr_nxt;
    r_r        <= r_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  // counter memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_READ) begin
      rd_r <= cnt_mem[touch_addr];
    end
  end

  // configuration writes
  assign reg_we = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_length_r <= FIELD_LENGTH_RST;
      sense_radius_r <= SENSE_RADIUS_RST;
      sink_x_r       <= SINK_X_RST;
      sink_y_r       <= SINK_Y_RST;
    end else if (reg_we) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_FIELD_LENGTH: field_length_r <= cfg_pwdata[8:0];
        REG_SENSE_RADIUS: sense_radius_r <= cfg_pwdata[3:0];
        REG_SINK_X:       sink_x_r       <= cfg_pwdata[7:0];
        REG_SINK_Y:       sink_y_r       <= cfg_pwdata[7:0];
        default:          sink_y_r       <= sink_y_r;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_FIELD_LENGTH: cfg_prdata = CFG_DATA_W'(field_length_r);
      REG_SENSE_RADIUS: cfg_prdata = CFG_DATA_W'(sense_radius_r);
      REG_SINK_X:       cfg_prdata = CFG_DATA_W'(sink_x_r);
      REG_SINK_Y:       cfg_prdata = CFG_DATA_W'(sink_y_r);
      default:          cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // stream handshakes
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule
